// ===== rtl/jts_pkg.sv =====
// Shared types, character codes and helper functions for the JSON token scanner.
`timescale 1ns / 1ps

package jts_pkg;

  localparam int unsigned MaxTextLenDefault = 65536;
  localparam int unsigned PosW              = 16;

  // Result queue: up to three results come out of one input byte.
  localparam int unsigned PushMax   = 3;
  localparam int unsigned PushCntW  = $clog2(PushMax + 1);
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoAw + 1;

  typedef enum logic [3:0] {
    KIND_LBRACE  = 4'd0,
    KIND_RBRACE  = 4'd1,
    KIND_LBRACK  = 4'd2,
    KIND_RBRACK  = 4'd3,
    KIND_COLON   = 4'd4,
    KIND_COMMA   = 4'd5,
    KIND_STRING  = 4'd6,
    KIND_TRUE    = 4'd7,
    KIND_FALSE   = 4'd8,
    KIND_NULL    = 4'd9,
    KIND_INT     = 4'd10,
    KIND_DEC     = 4'd11,
    KIND_END     = 4'd12
  } kind_e;

  typedef enum logic [19:0] {
    ST_BEGIN     = 20'h00001,
    ST_OPEN      = 20'h00002,
    ST_STRING    = 20'h00004,
    ST_ESCAPE    = 20'h00008,
    ST_NUM_SIGN  = 20'h00010,
    ST_NUM_POINT = 20'h00020,
    ST_NUM_INT   = 20'h00040,
    ST_NUM_FRAC  = 20'h00080,
    ST_AFTER     = 20'h00100,
    ST_N         = 20'h00200,
    ST_NU        = 20'h00400,
    ST_NUL       = 20'h00800,
    ST_T         = 20'h01000,
    ST_TR        = 20'h02000,
    ST_TRU       = 20'h04000,
    ST_F         = 20'h08000,
    ST_FA        = 20'h10000,
    ST_FAL       = 20'h20000,
    ST_FALS      = 20'h40000,
    ST_ERROR     = 20'h80000
  } scan_state_e;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef struct packed {
    kind_e             kind;
    logic [PosW-1:0]   start_pos;
    logic [PosW-1:0]   end_pos;
    logic              parse_error;
    logic              last_result;
  } token_t;

  // Results handed from the scanner to the result queue in the same cycle.
  typedef struct packed {
    logic [PushCntW-1:0]        count;
    token_t [PushMax-1:0]       tok;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_close(input logic [7:0] c);
    return (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_COLON) || (c == CH_COMMA);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic num_term(input logic [7:0] c);
    return is_space(c) || is_sep(c) || is_close(c);
  endfunction

  function automatic kind_e punct_kind(input logic [7:0] c);
    kind_e k;
    unique case (c)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_COLON:  k = KIND_COLON;
      default:   k = KIND_COMMA;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/jts_if.sv =====
// Channel interfaces of the JSON token scanner: byte input and token output.
`timescale 1ns / 1ps

interface jts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface jts_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] end_pos;
  logic        parse_error;
  logic        last_result;

  modport source (output valid, output token_kind, output start_pos, output end_pos,
                  output parse_error, output last_result, input ready);
  modport sink   (input valid, input token_kind, input start_pos, input end_pos,
                  input parse_error, input last_result, output ready);
endinterface

// ===== rtl/jts_scan.sv =====
// Input register and per-byte scanning state machine of the JSON token scanner.
`timescale 1ns / 1ps

module jts_scan #(
  parameter int unsigned MAX_TEXT_LEN = jts_pkg::MaxTextLenDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_text_i,
  input  logic           room_i,
  output jts_pkg::push_t push_o
);
  import jts_pkg::*;

  localparam int unsigned PosCntW = $clog2(MAX_TEXT_LEN + 1);

  logic                in_valid_q;
  logic [7:0]          byte_q;
  logic                eot_q;
  logic                advance;

  scan_state_e         state_q, st_d;
  logic [PosCntW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]     vs_q, vs_d;

  logic [7:0]          c;
  logic [PosW-1:0]     pos16, pos1, len16;
  logic                overflow, begin_path, after_term, err;
  logic                a_v, b_v, c_v;
  token_t              tok_a, tok_b, tok_c, tok_d;
  push_t               push;

  assign advance    = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BEGIN;
      pos_q   <= '0;
      vs_q    <= '0;
    end else if (advance) begin
      state_q <= st_d;
      pos_q   <= pos_d;
      vs_q    <= vs_d;
    end
  end

  always_comb begin
    c          = byte_q;
    pos16      = PosW'(pos_q);
    pos1       = pos16 + 16'd1;
    st_d       = state_q;
    vs_d       = vs_q;
    a_v        = 1'b0;
    b_v        = 1'b0;
    c_v        = 1'b0;
    err        = 1'b0;
    begin_path = 1'b0;
    after_term = 1'b0;
    tok_a      = '{kind: punct_kind(c), start_pos: pos16, end_pos: pos1,
                   parse_error: 1'b0, last_result: 1'b0};
    tok_b      = '{kind: punct_kind(c), start_pos: pos16, end_pos: pos1,
                   parse_error: 1'b0, last_result: 1'b0};

    unique case (state_q)
      ST_BEGIN: begin_path = 1'b1;
      ST_OPEN: begin
        if (is_space(c)) begin
          st_d = ST_OPEN;
        end else if (is_close(c)) begin
          a_v  = 1'b1;
          st_d = ST_AFTER;
        end else begin
          begin_path = 1'b1;
        end
      end
      ST_STRING: begin
        if (c == CH_QUOTE) begin
          a_v             = 1'b1;
          tok_a.kind      = KIND_STRING;
          tok_a.start_pos = vs_q;
          tok_a.end_pos   = pos16;
          st_d            = ST_AFTER;
        end else if (c == CH_BSLASH) begin
          st_d = ST_ESCAPE;
        end
      end
      ST_ESCAPE: st_d = ST_STRING;
      ST_NUM_SIGN: begin
        if (c == CH_ZERO) begin
          st_d = ST_NUM_POINT;
        end else if (c >= CH_ONE && c <= CH_NINE) begin
          st_d = ST_NUM_INT;
        end else begin
          st_d = ST_ERROR;
        end
      end
      ST_NUM_INT, ST_NUM_POINT: begin
        if (state_q == ST_NUM_INT && is_digit(c)) begin
          st_d = ST_NUM_INT;
        end else if (c == CH_POINT) begin
          st_d = ST_NUM_FRAC;
        end else if (num_term(c)) begin
          a_v             = 1'b1;
          tok_a.kind      = KIND_INT;
          tok_a.start_pos = vs_q;
          tok_a.end_pos   = pos16;
          st_d            = ST_AFTER;
          after_term      = 1'b1;
        end else begin
          st_d = ST_ERROR;
        end
      end
      ST_NUM_FRAC: begin
        if (is_digit(c)) begin
          st_d = ST_NUM_FRAC;
        end else if (num_term(c)) begin
          a_v             = 1'b1;
          tok_a.kind      = KIND_DEC;
          tok_a.start_pos = vs_q;
          tok_a.end_pos   = pos16;
          st_d            = ST_AFTER;
          after_term      = 1'b1;
        end else begin
          st_d = ST_ERROR;
        end
      end
      ST_AFTER: begin
        if (is_space(c)) begin
          st_d = ST_AFTER;
        end else if (is_sep(c) || is_close(c)) begin
          a_v = 1'b1;
        end else begin
          begin_path = 1'b1;
        end
      end
      ST_N:  st_d = (c == CH_U) ? ST_NU  : ST_ERROR;
      ST_NU: st_d = (c == CH_L) ? ST_NUL : ST_ERROR;
      ST_T:  st_d = (c == CH_R) ? ST_TR  : ST_ERROR;
      ST_TR: st_d = (c == CH_U) ? ST_TRU : ST_ERROR;
      ST_F:  st_d = (c == CH_A) ? ST_FA  : ST_ERROR;
      ST_FA: st_d = (c == CH_L) ? ST_FAL : ST_ERROR;
      ST_FAL: st_d = (c == CH_S) ? ST_FALS : ST_ERROR;
      ST_NUL, ST_TRU, ST_FALS: begin
        if ((state_q == ST_NUL && c == CH_L) || (state_q != ST_NUL && c == CH_E)) begin
          a_v             = 1'b1;
          tok_a.kind      = (state_q == ST_NUL) ? KIND_NULL :
                            (state_q == ST_TRU) ? KIND_TRUE : KIND_FALSE;
          tok_a.start_pos = vs_q;
          tok_a.end_pos   = pos1;
          st_d            = ST_AFTER;
        end else begin
          st_d = ST_ERROR;
        end
      end
      ST_ERROR: st_d = ST_ERROR;
      default:  st_d = ST_ERROR;
    endcase

    // Start of a new value, reached directly, after an opening bracket, or after a value or separator.
    if (begin_path) begin
      priority if (is_space(c)) begin
        st_d = ST_BEGIN;
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
        a_v  = 1'b1;
        st_d = ST_OPEN;
      end else if (c == CH_QUOTE) begin
        vs_d = pos1;
        st_d = ST_STRING;
      end else if (is_digit(c)) begin
        vs_d = pos16;
        st_d = (c == CH_ZERO) ? ST_NUM_POINT : ST_NUM_INT;
      end else if (c == CH_MINUS) begin
        vs_d = pos16;
        st_d = ST_NUM_SIGN;
      end else if (c == CH_T) begin
        vs_d = pos16;
        st_d = ST_T;
      end else if (c == CH_F) begin
        vs_d = pos16;
        st_d = ST_F;
      end else if (c == CH_N) begin
        vs_d = pos16;
        st_d = ST_N;
      end else begin
        st_d = ST_ERROR;
      end
    end

    // The byte that ends a number may itself be a separator or closing bracket.
    if (after_term && (is_sep(c) || is_close(c))) begin
      b_v = 1'b1;
    end

    overflow = pos_q >= PosCntW'(MAX_TEXT_LEN);
    if (overflow) begin
      st_d  = ST_ERROR;
      a_v   = 1'b0;
      b_v   = 1'b0;
      pos_d = pos_q;
    end else begin
      pos_d = pos_q + PosCntW'(1);
    end

    len16 = PosW'(pos_d);
    tok_c = '{kind: KIND_INT, start_pos: vs_d, end_pos: len16,
              parse_error: 1'b0, last_result: 1'b0};

    if (eot_q) begin
      if (st_d == ST_NUM_POINT || st_d == ST_NUM_INT) begin
        c_v  = 1'b1;
        st_d = ST_AFTER;
      end else if (st_d == ST_NUM_FRAC) begin
        c_v        = 1'b1;
        tok_c.kind = KIND_DEC;
        st_d       = ST_AFTER;
      end
      err   = !(st_d == ST_AFTER || st_d == ST_OPEN);
      st_d  = ST_BEGIN;
      vs_d  = '0;
      pos_d = '0;
    end

    tok_d = '{kind: KIND_END, start_pos: '0, end_pos: len16,
              parse_error: err, last_result: 1'b1};

    // A number closed at end of text never follows another result of the same byte.
    if (c_v) begin
      push.tok[0] = tok_c;
      push.tok[1] = tok_d;
      push.tok[2] = tok_d;
    end else begin
      push.tok[0] = a_v ? tok_a : tok_d;
      push.tok[1] = b_v ? tok_b : tok_d;
      push.tok[2] = tok_d;
    end
    push.count = PushCntW'(a_v) + PushCntW'(b_v) + PushCntW'(c_v) + PushCntW'(eot_q);
    if (!advance) begin
      push.count = '0;
    end
  end

  assign push_o = push;

endmodule

// ===== rtl/jts_fifo.sv =====
// Result queue: takes up to three tokens per cycle and hands out one per cycle while the reader is ready.
`timescale 1ns / 1ps

module jts_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jts_pkg::push_t  push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output jts_pkg::token_t tok_o
);
  import jts_pkg::*;

  token_t               mem_q [FifoDepth];
  logic [FifoAw-1:0]    wr_q, rd_q;
  logic [FifoCntW-1:0]  cnt_q;
  logic                 pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign tok_o   = mem_q[rd_q];
  // Room for the largest burst one byte can cause.
  assign room_o  = cnt_q <= FifoCntW'(FifoDepth - PushMax);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PushMax; i++) begin
      if (push_i.count > PushCntW'(i)) begin
        mem_q[wr_q + FifoAw'(i)] <= push_i.tok[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoAw'(push_i.count);
      rd_q  <= rd_q + FifoAw'(pop);
      cnt_q <= cnt_q + FifoCntW'(push_i.count) - FifoCntW'(pop);
    end
  end

endmodule

// ===== rtl/json_token_scanner.sv =====
// Data path: an accepted byte is held in the input register, and the scanner writes
// its results into the result queue, which presents the first of them on the output.
// Throughput: one byte per cycle while the queue has room; results leave at one per
// cycle while the output is ready, so a byte that ends a number and a separator at
// once, or ends the text, gives two or three results; an eight-entry result queue
// absorbs these bursts; the input stalls while the queue holds more than five results.
// Reset: asynchronous; the scanner returns to its begin state at position zero
// and the input register and result queue empty.
`timescale 1ns / 1ps

module json_token_scanner #(
  parameter int unsigned MAX_TEXT_LEN = jts_pkg::MaxTextLenDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  jts_in_if.sink           in_i,
  jts_tok_if.source        tok_o
);
  import jts_pkg::*;

  push_t  push;
  logic   room;
  token_t tok;

  jts_scan #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .data_byte_i   (in_i.data_byte),
    .end_of_text_i (in_i.end_of_text),
    .room_i        (room),
    .push_o        (push)
  );

  jts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (tok_o.valid),
    .ready_i (tok_o.ready),
    .tok_o   (tok)
  );

  assign tok_o.token_kind  = tok.kind;
  assign tok_o.start_pos   = tok.start_pos;
  assign tok_o.end_pos     = tok.end_pos;
  assign tok_o.parse_error = tok.parse_error;
  assign tok_o.last_result = tok.last_result;

endmodule

// ===== rtl/jts_checker.sv =====
// Port-level checks on the JSON token scanner and the bind that attaches them.
`timescale 1ns / 1ps

module jts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tok_valid_i,
  input logic        tok_ready_i,
  input logic [3:0]  token_kind_i,
  input logic [15:0] start_pos_i,
  input logic [15:0] end_pos_i,
  input logic        parse_error_i,
  input logic        last_result_i
);
  import jts_pkg::*;

  // A token that waits stays valid and keeps its kind, positions and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_ready_i |=> tok_valid_i && $stable(token_kind_i)
      && $stable(start_pos_i) && $stable(end_pos_i) && $stable(last_result_i))
    else $error("token changed while stalled");

  // The end result and only the end result is marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i |-> ((token_kind_i == KIND_END) == last_result_i))
    else $error("end kind and last flag disagree");

  // Errors are reported on the end result only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && parse_error_i |-> last_result_i)
    else $error("error flag on a non-final result");

  // The end result starts at offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && last_result_i |-> start_pos_i == 16'd0)
    else $error("end result with nonzero start");

endmodule

bind json_token_scanner jts_checker u_jts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .tok_valid_i   (tok_o.valid),
  .tok_ready_i   (tok_o.ready),
  .token_kind_i  (tok_o.token_kind),
  .start_pos_i   (tok_o.start_pos),
  .end_pos_i     (tok_o.end_pos),
  .parse_error_i (tok_o.parse_error),
  .last_result_i (tok_o.last_result)
);
